// File: src/njs_pkg.sv
// Shared types and constants of the network join sequencer.
package njs_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_CHECK   = 3'd1,
        PH_WRITE   = 3'd2,
        PH_START   = 3'd3,
        PH_ONNET   = 3'd4,
        PH_RECOVER = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_READ     = 3'd1,
        CMD_WRITE    = 3'd2,
        CMD_STARTNET = 3'd3,
        CMD_INFO     = 3'd4,
        CMD_SYSRESET = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        TM_LEAVE = 2'd0,
        TM_START = 2'd1,
        TM_STOP  = 2'd2
    } tact_t;

    typedef enum logic [2:0] {
        EV_RESET_IND  = 3'd0,
        EV_READ_RESP  = 3'd1,
        EV_WRITE_RESP = 3'd2,
        EV_NET_STATUS = 3'd3,
        EV_INFO_RESP  = 3'd4,
        EV_TIMEOUT    = 3'd5,
        EV_RESTART    = 3'd6
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WANTED_TYPE    = 3'd0,
        CFG_EXPECTED_STATE = 3'd1,
        CFG_RESPONSE_WAIT  = 3'd2,
        CFG_RESET_WAIT     = 3'd3,
        CFG_JOIN_WAIT      = 3'd4,
        CFG_RETRY_DELAY    = 3'd5,
        CFG_RETRY_LIMIT    = 3'd6,
        CFG_START_MODE     = 3'd7
    } cfg_idx_t;

    localparam logic [1:0]  RST_WANTED_TYPE    = 2'd0;
    localparam logic [7:0]  RST_EXPECTED_STATE = 8'd9;
    localparam logic [15:0] RST_RESPONSE_WAIT  = 16'd500;
    localparam logic [15:0] RST_RESET_WAIT     = 16'd5000;
    localparam logic [15:0] RST_JOIN_WAIT      = 16'd10000;
    localparam logic [15:0] RST_RETRY_DELAY    = 16'd5000;
    localparam logic [7:0]  RST_RETRY_LIMIT    = 8'd10;
    localparam logic [7:0]  RST_START_MODE     = 8'h02;

    typedef struct packed {
        logic [1:0]  wanted_type;
        logic [7:0]  expected_state;
        logic [15:0] response_wait;
        logic [15:0] reset_wait;
        logic [15:0] join_wait;
        logic [15:0] retry_delay;
        logic [7:0]  retry_limit;
        logic [7:0]  start_mode;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  status;
        logic [7:0]  device_value;
        logic [15:0] own_short_addr;
        logic [63:0] own_long_addr;
        logic [15:0] parent_short_addr;
        logic [63:0] parent_long_addr;
        logic [7:0]  radio_channel;
        logic [15:0] pan_ident;
    } evt_t;

    typedef struct packed {
        cmd_t        command;
        logic [7:0]  command_arg;
        tact_t       timer_action;
        logic [15:0] timer_ms;
        phase_t      phase;
        logic        on_net;
        logic [7:0]  error_total;
        logic        info_valid;
        logic [15:0] net_short_addr;
        logic [15:0] net_pan;
        logic [7:0]  net_channel;
    } res_t;

endpackage

// File: src/njs_cfg_regs.sv
// Configuration register file of the network join sequencer.
module njs_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [njs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [njs_pkg::CFG_DATA_W-1:0] cfg_data,
    output njs_pkg::cfg_t                  cfg
);
    import njs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_WANTED_TYPE:    cfg_next.wanted_type    = cfg_data[1:0];
                CFG_EXPECTED_STATE: cfg_next.expected_state = cfg_data[7:0];
                CFG_RESPONSE_WAIT:  cfg_next.response_wait  = cfg_data[15:0];
                CFG_RESET_WAIT:     cfg_next.reset_wait     = cfg_data[15:0];
                CFG_JOIN_WAIT:      cfg_next.join_wait      = cfg_data[15:0];
                CFG_RETRY_DELAY:    cfg_next.retry_delay    = cfg_data[15:0];
                CFG_RETRY_LIMIT:    cfg_next.retry_limit    = cfg_data[7:0];
                CFG_START_MODE:     cfg_next.start_mode     = cfg_data[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wanted_type    <= RST_WANTED_TYPE;
            cfg_reg.expected_state <= RST_EXPECTED_STATE;
            cfg_reg.response_wait  <= RST_RESPONSE_WAIT;
            cfg_reg.reset_wait     <= RST_RESET_WAIT;
            cfg_reg.join_wait      <= RST_JOIN_WAIT;
            cfg_reg.retry_delay    <= RST_RETRY_DELAY;
            cfg_reg.retry_limit    <= RST_RETRY_LIMIT;
            cfg_reg.start_mode     <= RST_START_MODE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/njs_in_stage.sv
// Input register stage that captures one event item per cycle while it is not stalled.
module njs_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  njs_pkg::evt_t in_evt,
    input  logic          advance,
    output logic          evt_valid,
    output njs_pkg::evt_t evt
);
    import njs_pkg::*;

    logic valid_reg;
    logic valid_next;
    evt_t evt_reg;
    logic load;

    assign in_stall   = valid_reg && !advance;
    assign load       = in_valid && !in_stall;
    assign valid_next = load || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            evt_reg <= in_evt;
        end
    end

    assign evt_valid = valid_reg;
    assign evt       = evt_reg;

endmodule

// File: src/njs_core.sv
// Join state machine, learned network info and result register.
module njs_core (
    input  logic          clk,
    input  logic          rst_n,
    input  njs_pkg::cfg_t cfg,
    input  logic          evt_valid,
    input  njs_pkg::evt_t evt,
    input  logic          advance,
    output logic          res_valid,
    output njs_pkg::res_t res
);
    import njs_pkg::*;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [7:0]  err_reg;
    logic [7:0]  err_next;
    logic [7:0]  err_inc;
    logic        info_valid_reg;
    logic        info_valid_next;
    logic        store_info;
    logic [15:0] short_addr_reg;
    logic [63:0] long_addr_reg;
    logic [15:0] parent_short_reg;
    logic [63:0] parent_long_reg;
    logic [7:0]  channel_reg;
    logic [15:0] pan_reg;
    cmd_t        cmd;
    logic [7:0]  cmd_arg;
    tact_t       tact;
    logic [15:0] tms;
    logic        res_valid_reg;
    res_t        res_reg;
    logic        step;

    assign step    = evt_valid && advance;
    assign err_inc = (err_reg == 8'hFF) ? err_reg : err_reg + 8'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        err_next        = err_reg;
        info_valid_next = info_valid_reg;
        store_info      = 1'b0;
        unique case (evt.kind)
            EV_RESET_IND:
            begin
                phase_next = PH_CHECK;
            end
            EV_READ_RESP:
            begin
                if (evt.status != 8'd0)
                begin
                    err_next   = err_inc;
                    phase_next = PH_IDLE;
                end
                else if (evt.device_value == {6'd0, cfg.wanted_type})
                begin
                    phase_next = PH_START;
                end
                else
                begin
                    phase_next = PH_WRITE;
                end
            end
            EV_WRITE_RESP:
            begin
                if (evt.status != 8'd0)
                begin
                    err_next = err_inc;
                end
                phase_next = PH_IDLE;
            end
            EV_NET_STATUS:
            begin
                phase_next = (evt.status == 8'd0) ? PH_ONNET : PH_RECOVER;
            end
            EV_INFO_RESP:
            begin
                if (evt.device_value != cfg.expected_state)
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    store_info      = 1'b1;
                    info_valid_next = 1'b1;
                end
            end
            EV_TIMEOUT:
            begin
                err_next = err_inc;
                if (err_inc > cfg.retry_limit)
                begin
                    phase_next = PH_IDLE;
                end
                else if (phase_reg != PH_START && phase_reg != PH_RECOVER &&
                         phase_reg != PH_ONNET)
                begin
                    phase_next = PH_CHECK;
                end
            end
            EV_RESTART:
            begin
                phase_next      = PH_IDLE;
                err_next        = 8'd0;
                info_valid_next = 1'b0;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_comb
    begin
        cmd     = CMD_NONE;
        cmd_arg = 8'd0;
        tact    = TM_LEAVE;
        tms     = 16'd0;
        unique case (evt.kind)
            EV_RESET_IND:
            begin
                cmd  = CMD_READ;
                tact = TM_START;
                tms  = cfg.response_wait;
            end
            EV_READ_RESP:
            begin
                tact = TM_START;
                if (evt.status != 8'd0)
                begin
                    cmd = CMD_SYSRESET;
                    tms = cfg.reset_wait;
                end
                else if (evt.device_value == {6'd0, cfg.wanted_type})
                begin
                    cmd     = CMD_STARTNET;
                    cmd_arg = cfg.start_mode;
                    tms     = cfg.join_wait;
                end
                else
                begin
                    cmd     = CMD_WRITE;
                    cmd_arg = {6'd0, cfg.wanted_type};
                    tms     = cfg.response_wait;
                end
            end
            EV_WRITE_RESP, EV_RESTART:
            begin
                cmd  = CMD_SYSRESET;
                tact = TM_START;
                tms  = cfg.reset_wait;
            end
            EV_NET_STATUS:
            begin
                tact = TM_START;
                if (evt.status == 8'd0)
                begin
                    cmd = CMD_INFO;
                    tms = cfg.response_wait;
                end
                else
                begin
                    tms = cfg.retry_delay;
                end
            end
            EV_INFO_RESP:
            begin
                if (evt.device_value != cfg.expected_state)
                begin
                    tact = TM_START;
                    tms  = cfg.response_wait;
                end
                else
                begin
                    tact = TM_STOP;
                end
            end
            EV_TIMEOUT:
            begin
                if (err_inc <= cfg.retry_limit)
                begin
                    tact = TM_START;
                    if (phase_reg == PH_START || phase_reg == PH_RECOVER)
                    begin
                        cmd     = CMD_STARTNET;
                        cmd_arg = cfg.start_mode;
                        tms     = cfg.join_wait;
                    end
                    else if (phase_reg == PH_ONNET)
                    begin
                        cmd = CMD_INFO;
                        tms = cfg.response_wait;
                    end
                    else
                    begin
                        cmd = CMD_READ;
                        tms = cfg.response_wait;
                    end
                end
            end
            default:
            begin
                cmd = CMD_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            err_reg          <= 8'd0;
            info_valid_reg   <= 1'b0;
            short_addr_reg   <= 16'd0;
            long_addr_reg    <= 64'd0;
            parent_short_reg <= 16'd0;
            parent_long_reg  <= 64'd0;
            channel_reg      <= 8'd0;
            pan_reg          <= 16'd0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                res_valid_reg <= evt_valid;
            end
            if (step)
            begin
                phase_reg      <= phase_next;
                err_reg        <= err_next;
                info_valid_reg <= info_valid_next;
                if (store_info)
                begin
                    short_addr_reg   <= evt.own_short_addr;
                    long_addr_reg    <= evt.own_long_addr;
                    parent_short_reg <= evt.parent_short_addr;
                    parent_long_reg  <= evt.parent_long_addr;
                    channel_reg      <= evt.radio_channel;
                    pan_reg          <= evt.pan_ident;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg.command        <= cmd;
            res_reg.command_arg    <= cmd_arg;
            res_reg.timer_action   <= tact;
            res_reg.timer_ms       <= tms;
            res_reg.phase          <= phase_next;
            res_reg.on_net         <= (phase_next == PH_ONNET) && info_valid_next;
            res_reg.error_total    <= err_next;
            res_reg.info_valid     <= info_valid_next;
            res_reg.net_short_addr <= store_info ? evt.own_short_addr : short_addr_reg;
            res_reg.net_pan        <= store_info ? evt.pan_ident : pan_reg;
            res_reg.net_channel    <= store_info ? evt.radio_channel : channel_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: src/network_join_sequencer.sv
// Top level of the network join sequencer.
//
//  Channel | Handshake               | Payload
//  --------+-------------------------+------------------------------------------
//  in      | in_valid / in_stall     | kind, status, device_value, addresses, ...
//  out     | out_valid / out_stall   | command, timer action, phase and net info
//  cfg     | cfg_we                  | cfg_index, cfg_data
//
// One item is accepted per cycle while the output is not stalled; each result
// passes through the input register and then the result register.
// Reset returns the phase to idle, clears errors and stored info, and loads
// the configuration defaults.
// A stall on the output holds both stages and reaches in_stall in the same cycle.
module network_join_sequencer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [njs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [njs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     kind,
    input  logic [7:0]                     status,
    input  logic [7:0]                     device_value,
    input  logic [15:0]                    own_short_addr,
    input  logic [63:0]                    own_long_addr,
    input  logic [15:0]                    parent_short_addr,
    input  logic [63:0]                    parent_long_addr,
    input  logic [7:0]                     radio_channel,
    input  logic [15:0]                    pan_ident,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [2:0]                     command,
    output logic [7:0]                     command_arg,
    output logic [1:0]                     timer_action,
    output logic [15:0]                    timer_ms,
    output logic [2:0]                     phase,
    output logic                           on_net,
    output logic [7:0]                     error_total,
    output logic                           info_valid,
    output logic [15:0]                    net_short_addr,
    output logic [15:0]                    net_pan,
    output logic [7:0]                     net_channel
);
    import njs_pkg::*;

    cfg_t cfg;
    evt_t in_evt;
    evt_t evt;
    logic evt_valid;
    logic advance;
    res_t res;

    assign in_evt.kind              = kind;
    assign in_evt.status            = status;
    assign in_evt.device_value      = device_value;
    assign in_evt.own_short_addr    = own_short_addr;
    assign in_evt.own_long_addr     = own_long_addr;
    assign in_evt.parent_short_addr = parent_short_addr;
    assign in_evt.parent_long_addr  = parent_long_addr;
    assign in_evt.radio_channel     = radio_channel;
    assign in_evt.pan_ident         = pan_ident;

    assign advance = !out_valid || !out_stall;

    njs_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    njs_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_evt    (in_evt),
        .advance   (advance),
        .evt_valid (evt_valid),
        .evt       (evt)
    );

    njs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .evt_valid (evt_valid),
        .evt       (evt),
        .advance   (advance),
        .res_valid (out_valid),
        .res       (res)
    );

    assign command        = res.command;
    assign command_arg    = res.command_arg;
    assign timer_action   = res.timer_action;
    assign timer_ms       = res.timer_ms;
    assign phase          = res.phase;
    assign on_net         = res.on_net;
    assign error_total    = res.error_total;
    assign info_valid     = res.info_valid;
    assign net_short_addr = res.net_short_addr;
    assign net_pan        = res.net_pan;
    assign net_channel    = res.net_channel;

`ifndef NO_ASSERTIONS
    a_on_net_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && on_net |-> info_valid && phase == PH_ONNET)
        else $error("on_net set without valid info in the on-net phase");

    a_timer_ms_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && timer_action != TM_START |-> timer_ms == 16'd0)
        else $error("timer duration given without a timer start");

    a_sysreset_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command == CMD_SYSRESET |-> phase == PH_IDLE && timer_action == TM_START)
        else $error("system reset issued outside idle or without a timer start");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> evt_valid && out_valid && out_stall)
        else $error("input stalled while the pipeline can move");
`endif

endmodule
